// ----- hdl/rar_pkg.sv -----
package rar_pkg;

    // Default operand width and fixed result widths
    localparam int OPERAND_WIDTH = 16;
    localparam int RES_NUM_W     = 33;
    localparam int RES_DEN_W     = 31;

    // Item commands
    typedef enum logic [1:0] {
        CMD_NORM = 2'd0,
        CMD_ADD  = 2'd1,
        CMD_DIV  = 2'd2,
        CMD_INC  = 2'd3
    } cmd_t;

    // Multiplier operand pairs
    typedef enum logic [1:0] {
        MS_AN_BD,
        MS_AD_BN,
        MS_AD_BD
    } mul_sel_t;

    // Numerator register update
    typedef enum logic [1:0] {
        NUM_HOLD,
        NUM_PROD,
        NUM_ACC,
        NUM_FORM
    } num_op_t;

    // Denominator register update
    typedef enum logic [1:0] {
        DEN_HOLD,
        DEN_PROD,
        DEN_FORM
    } den_op_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        num_op_t  num_op;
        den_op_t  den_op;
        logic     abs_init;
        logic     gcd_step;
        logic     div_init;
        logic     div_step;
        logic     out_load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        cmd_t cmd;
        logic err;
        logic zero_num;
        logic gcd_done;
        logic div_last;
    } dp_stat_t;

endpackage

// ----- hdl/rar_ctrl.sv -----
module rar_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output rar_pkg::dp_cmd_t   cmd,
    input  rar_pkg::dp_stat_t  stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_ABS,
        S_GCD,
        S_DIVI,
        S_DIV,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Decode state into datapath commands and next state
    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = rar_pkg::MS_AN_BD;
        cmd.num_op     = rar_pkg::NUM_HOLD;
        cmd.den_op     = rar_pkg::DEN_HOLD;
        state_next     = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.err)
                begin
                    state_next = S_DONE;
                end
                else if (stat.cmd == rar_pkg::CMD_ADD || stat.cmd == rar_pkg::CMD_DIV)
                begin
                    state_next = S_MUL0;
                end
                else
                begin
                    cmd.num_op = rar_pkg::NUM_FORM;
                    cmd.den_op = rar_pkg::DEN_FORM;
                    state_next = S_ABS;
                end
            end
            S_MUL0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rar_pkg::MS_AN_BD;
                state_next  = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rar_pkg::MS_AD_BN;
                cmd.num_op  = rar_pkg::NUM_PROD;
                state_next  = (stat.cmd == rar_pkg::CMD_DIV) ? S_MUL3 : S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rar_pkg::MS_AD_BD;
                cmd.num_op  = rar_pkg::NUM_ACC;
                state_next  = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.den_op = rar_pkg::DEN_PROD;
                state_next = S_ABS;
            end
            S_ABS:
            begin
                cmd.abs_init = 1'b1;
                state_next   = S_GCD;
            end
            S_GCD:
            begin
                if (stat.zero_num)
                begin
                    state_next = S_DONE;
                end
                else if (stat.gcd_done)
                begin
                    state_next = S_DIVI;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result valid until it is taken
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- hdl/rar_dpath.sv -----
module rar_dpath #(
    parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rar_pkg::dp_cmd_t                      cmd,
    output rar_pkg::dp_stat_t                     stat,
    input  logic [1:0]                            command,
    input  logic signed [OPERAND_WIDTH-1:0]       a_num,
    input  logic signed [OPERAND_WIDTH-1:0]       a_den,
    input  logic signed [OPERAND_WIDTH-1:0]       b_num,
    input  logic signed [OPERAND_WIDTH-1:0]       b_den,
    output logic signed [rar_pkg::RES_NUM_W-1:0]  res_num,
    output logic [rar_pkg::RES_DEN_W-1:0]         res_den,
    output logic                                  status
);

    localparam int W      = OPERAND_WIDTH;
    localparam int PW     = 2 * W;
    localparam int NW     = PW + 1;
    localparam int MW     = PW;
    localparam int KW     = $clog2(PW);
    localparam int CW     = $clog2(PW);
    localparam int NEXT_W = (MW + 1 > rar_pkg::RES_NUM_W) ? MW + 1 : rar_pkg::RES_NUM_W;
    localparam int DEXT_W = (MW > rar_pkg::RES_DEN_W) ? MW : rar_pkg::RES_DEN_W;

    // Captured item
    rar_pkg::cmd_t          cmd_reg;
    logic signed [W-1:0]    an_reg;
    logic signed [W-1:0]    ad_reg;
    logic signed [W-1:0]    bn_reg;
    logic signed [W-1:0]    bd_reg;

    // Raw fraction
    logic signed [PW-1:0]   prod_reg;
    logic signed [NW-1:0]   num_reg;
    logic signed [NW-1:0]   num_next;
    logic signed [PW-1:0]   den_reg;
    logic signed [PW-1:0]   den_next;

    // Magnitudes and gcd state
    logic [MW-1:0]          nmag_reg;
    logic [MW-1:0]          dmag_reg;
    logic                   neg_reg;
    logic [MW-1:0]          gu_reg;
    logic [MW-1:0]          gu_next;
    logic [MW-1:0]          gv_reg;
    logic [MW-1:0]          gv_next;
    logic [KW-1:0]          k_reg;
    logic [KW-1:0]          k_next;

    // Divider state
    logic [MW-1:0]          div_reg;
    logic [MW-1:0]          rn_reg;
    logic [MW-1:0]          qn_reg;
    logic [MW-1:0]          rd_reg;
    logic [MW-1:0]          qd_reg;
    logic [CW-1:0]          cnt_reg;

    // Result
    logic signed [rar_pkg::RES_NUM_W-1:0] res_num_reg;
    logic signed [rar_pkg::RES_NUM_W-1:0] res_num_next;
    logic [rar_pkg::RES_DEN_W-1:0]        res_den_reg;
    logic [rar_pkg::RES_DEN_W-1:0]        res_den_next;
    logic                                 status_reg;

    logic                   err;
    logic signed [W-1:0]    mul_a;
    logic signed [W-1:0]    mul_b;
    logic signed [PW-1:0]   mul_full;
    logic signed [NW-1:0]   prod_ext;
    logic signed [NW-1:0]   an_ext;
    logic signed [NW-1:0]   ad_ext;
    logic signed [PW-1:0]   ad_pext;
    logic                   nneg;
    logic                   dneg;
    logic signed [NW-1:0]   nabs;
    logic signed [PW-1:0]   dabs;
    logic [MW:0]            div_ext;
    logic [MW:0]            trial_n;
    logic [MW:0]            trial_d;
    logic [MW:0]            sub_n;
    logic [MW:0]            sub_d;
    logic                   ge_n;
    logic                   ge_d;
    logic [NEXT_W-1:0]      qn_ext;
    logic [NEXT_W-1:0]      sn_ext;
    logic [DEXT_W-1:0]      qd_ext;

    // Flag zero denominators and divide by zero
    assign err = (ad_reg == '0)
              || ((cmd_reg == rar_pkg::CMD_ADD || cmd_reg == rar_pkg::CMD_DIV) && bd_reg == '0)
              || (cmd_reg == rar_pkg::CMD_DIV && bn_reg == '0);

    // Select the operand pair for the shared multiplier
    always_comb
    begin
        case (cmd.mul_sel)
            rar_pkg::MS_AN_BD:
            begin
                mul_a = an_reg;
                mul_b = bd_reg;
            end
            rar_pkg::MS_AD_BN:
            begin
                mul_a = ad_reg;
                mul_b = bn_reg;
            end
            rar_pkg::MS_AD_BD:
            begin
                mul_a = ad_reg;
                mul_b = bd_reg;
            end
            default:
            begin
                mul_a = an_reg;
                mul_b = bd_reg;
            end
        endcase
    end

    assign mul_full = PW'(mul_a) * PW'(mul_b);
    assign prod_ext = NW'(prod_reg);
    assign an_ext   = NW'(an_reg);
    assign ad_ext   = NW'(ad_reg);
    assign ad_pext  = PW'(ad_reg);

    // Build the raw numerator and denominator
    always_comb
    begin
        case (cmd.num_op)
            rar_pkg::NUM_PROD: num_next = prod_ext;
            rar_pkg::NUM_ACC:  num_next = num_reg + prod_ext;
            rar_pkg::NUM_FORM: num_next = (cmd_reg == rar_pkg::CMD_INC) ? an_ext + ad_ext : an_ext;
            default:           num_next = num_reg;
        endcase
        case (cmd.den_op)
            rar_pkg::DEN_PROD: den_next = prod_reg;
            rar_pkg::DEN_FORM: den_next = ad_pext;
            default:           den_next = den_reg;
        endcase
    end

    // Split into sign and magnitudes
    assign nneg = num_reg[NW-1];
    assign dneg = den_reg[PW-1];
    assign nabs = nneg ? -num_reg : num_reg;
    assign dabs = dneg ? -den_reg : den_reg;

    // Binary gcd: strip common twos, halve even sides, subtract odd sides
    always_comb
    begin
        gu_next = gu_reg;
        gv_next = gv_reg;
        k_next  = k_reg;
        if (cmd.abs_init)
        begin
            gu_next = nabs[MW-1:0];
            gv_next = dabs[MW-1:0];
            k_next  = '0;
        end
        else if (cmd.gcd_step)
        begin
            if (!gu_reg[0] && !gv_reg[0])
            begin
                gu_next = gu_reg >> 1;
                gv_next = gv_reg >> 1;
                k_next  = k_reg + KW'(1);
            end
            else if (!gu_reg[0])
            begin
                gu_next = gu_reg >> 1;
            end
            else if (!gv_reg[0])
            begin
                gv_next = gv_reg >> 1;
            end
            else if (gu_reg > gv_reg)
            begin
                gu_next = (gu_reg - gv_reg) >> 1;
            end
            else
            begin
                gv_next = (gv_reg - gu_reg) >> 1;
            end
        end
    end

    // Restoring division, one quotient bit per cycle in each lane
    assign div_ext = {1'b0, div_reg};
    assign trial_n = {rn_reg, qn_reg[MW-1]};
    assign trial_d = {rd_reg, qd_reg[MW-1]};
    assign ge_n    = (trial_n >= div_ext);
    assign ge_d    = (trial_d >= div_ext);
    assign sub_n   = trial_n - div_ext;
    assign sub_d   = trial_d - div_ext;

    // Form the result item
    assign qn_ext = {{(NEXT_W - MW){1'b0}}, qn_reg};
    assign sn_ext = neg_reg ? -qn_ext : qn_ext;
    assign qd_ext = DEXT_W'(qd_reg);

    always_comb
    begin
        if (err)
        begin
            res_num_next = '0;
            res_den_next = '0;
        end
        else if (nmag_reg == '0)
        begin
            res_num_next = '0;
            res_den_next = rar_pkg::RES_DEN_W'(1);
        end
        else
        begin
            res_num_next = sn_ext[rar_pkg::RES_NUM_W-1:0];
            res_den_next = qd_ext[rar_pkg::RES_DEN_W-1:0];
        end
    end

    // Step counter for the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_init)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= rar_pkg::cmd_t'(command);
            an_reg  <= a_num;
            ad_reg  <= a_den;
            bn_reg  <= b_num;
            bd_reg  <= b_den;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_full;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        if (cmd.abs_init)
        begin
            nmag_reg <= nabs[MW-1:0];
            dmag_reg <= dabs[MW-1:0];
            neg_reg  <= nneg ^ dneg;
        end
        gu_reg <= gu_next;
        gv_reg <= gv_next;
        k_reg  <= k_next;
        if (cmd.div_init)
        begin
            div_reg <= gu_reg << k_reg;
            rn_reg  <= '0;
            qn_reg  <= nmag_reg;
            rd_reg  <= '0;
            qd_reg  <= dmag_reg;
        end
        else if (cmd.div_step)
        begin
            rn_reg <= ge_n ? sub_n[MW-1:0] : trial_n[MW-1:0];
            qn_reg <= {qn_reg[MW-2:0], ge_n};
            rd_reg <= ge_d ? sub_d[MW-1:0] : trial_d[MW-1:0];
            qd_reg <= {qd_reg[MW-2:0], ge_d};
        end
        if (cmd.out_load)
        begin
            res_num_reg <= res_num_next;
            res_den_reg <= res_den_next;
            status_reg  <= err;
        end
    end

    assign stat.cmd      = cmd_reg;
    assign stat.err      = err;
    assign stat.zero_num = (nmag_reg == '0);
    assign stat.gcd_done = (gu_reg == gv_reg);
    assign stat.div_last = (cnt_reg == CW'(PW - 1));

    assign res_num = res_num_reg;
    assign res_den = res_den_reg;
    assign status  = status_reg;

endmodule

// ----- hdl/rational_arith_reduce.sv -----
// Sequence from item accept to result valid: CHECK, then multiply states (add: MUL0 to MUL3,
// divide: MUL0, MUL1 and MUL3, normalize/increment: none), a magnitude state, the binary gcd
// loop, a divisor state, the divider loop and the output load.
// A zero numerator skips gcd and division; an error goes straight to the output register.
// One item in flight; the next is accepted the cycle after a result loads.
// Reset (async, active low) clears controller, output valid, divider count.
module rational_arith_reduce #(
    parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            command,
    input  logic signed [OPERAND_WIDTH-1:0]       a_num,
    input  logic signed [OPERAND_WIDTH-1:0]       a_den,
    input  logic signed [OPERAND_WIDTH-1:0]       b_num,
    input  logic signed [OPERAND_WIDTH-1:0]       b_den,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [rar_pkg::RES_NUM_W-1:0]  res_num,
    output logic [rar_pkg::RES_DEN_W-1:0]         res_den,
    output logic                                  status
);

    rar_pkg::dp_cmd_t  dp_cmd;
    rar_pkg::dp_stat_t dp_stat;

    // Sequence the item through multiply, gcd and divide
    rar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

    // Arithmetic and result register
    rar_dpath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (dp_cmd),
        .stat    (dp_stat),
        .command (command),
        .a_num   (a_num),
        .a_den   (a_den),
        .b_num   (b_num),
        .b_den   (b_den),
        .res_num (res_num),
        .res_den (res_den),
        .status  (status)
    );

endmodule

// ----- tb/rational_arith_reduce_test.sv -----
module rational_arith_reduce_test;

    localparam int OW     = rar_pkg::OPERAND_WIDTH;
    localparam int OP_MAX = 2 ** (OW - 1) - 1;
    localparam int OP_MIN = -(2 ** (OW - 1));

    typedef logic signed [OW-1:0] operand_t;

    typedef struct {
        rar_pkg::cmd_t cmd;
        operand_t      an;
        operand_t      ad;
        operand_t      bn;
        operand_t      bd;
    } operands_t;

    typedef struct {
        logic signed [rar_pkg::RES_NUM_W-1:0] num;
        logic [rar_pkg::RES_DEN_W-1:0]        den;
        logic                                 err;
    } fraction_t;

    typedef struct packed {
        longint num;
        longint den;
    } ratio_t;

    typedef enum {FULL_RANGE, SMALL_FACTORS, EXTREMES} operand_mix_t;

    logic                                 clk;
    logic                                 rst_n     = 1'b0;
    logic                                 in_valid  = 1'b0;
    logic                                 in_ready;
    logic [1:0]                           command   = '0;
    operand_t                             a_num     = '0;
    operand_t                             a_den     = '0;
    operand_t                             b_num     = '0;
    operand_t                             b_den     = '0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic signed [rar_pkg::RES_NUM_W-1:0] res_num;
    logic [rar_pkg::RES_DEN_W-1:0]        res_den;
    logic                                 status;

    fraction_t expected_fractions[$];
    int        mismatches     = 0;
    int        results_seen   = 0;
    int        error_items    = 0;
    int        cmd_count[4]   = '{0, 0, 0, 0};
    bit        sender_idles   = 1'b1;
    bit        receiver_idles = 1'b1;
    int        stall_left     = 0;

    rational_arith_reduce DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .a_num    (a_num),
        .a_den    (a_den),
        .b_num    (b_num),
        .b_den    (b_den),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .res_num  (res_num),
        .res_den  (res_den),
        .status   (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #(12 * 1500000);
        $display("timeout: %0d results still pending", expected_fractions.size());
        $display("TB_ERROR");
        $finish;
    end

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint euclid_gcd(longint x, longint y);
        longint t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Divide out the gcd, move the sign to the numerator, zero becomes 0/1
    function automatic ratio_t lowest_terms(longint n, longint d);
        ratio_t r;
        longint g;
        g     = euclid_gcd(magnitude(n), magnitude(d));
        r.num = magnitude(n) / g;
        r.den = magnitude(d) / g;
        if (r.num == 0)
            r.den = 1;
        else if ((n < 0) != (d < 0))
            r.num = -r.num;
        return r;
    endfunction

    function automatic fraction_t reduced_fraction(operands_t op);
        fraction_t res;
        ratio_t    a;
        ratio_t    b;
        ratio_t    r;
        longint    an;
        longint    ad;
        longint    bn;
        longint    bd;
        longint    rn;
        longint    rd;
        an = op.an;
        ad = op.ad;
        bn = op.bn;
        bd = op.bd;
        res.num = '0;
        res.den = '0;
        res.err = 1'b1;
        // Zero denominator, or divide by a zero b
        if (ad == 0 || ((op.cmd == rar_pkg::CMD_ADD || op.cmd == rar_pkg::CMD_DIV) && bd == 0) ||
            (op.cmd == rar_pkg::CMD_DIV && bn == 0))
            return res;
        a = lowest_terms(an, ad);
        b = lowest_terms(bn, (bd == 0) ? 1 : bd);
        case (op.cmd)
            rar_pkg::CMD_NORM: r = a;
            rar_pkg::CMD_INC:  r = lowest_terms(a.num + a.den, a.den);
            rar_pkg::CMD_ADD:  r = lowest_terms(a.num * b.den + a.den * b.num, a.den * b.den);
            default:           r = lowest_terms(a.num * b.den, a.den * b.num);
        endcase
        rn = r.num;
        rd = r.den;
        res.num = rn[rar_pkg::RES_NUM_W-1:0];
        res.den = rd[rar_pkg::RES_DEN_W-1:0];
        res.err = 1'b0;
        return res;
    endfunction

    // Mostly no gap, some short, a few long
    function automatic int pick_idle(bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 60);
    endfunction

    function automatic operand_t random_operand(operand_mix_t mix);
        int v;
        case (mix)
            SMALL_FACTORS:
            begin
                // Small values sharing factors keep the gcd busy
                v = (int'($urandom_range(0, 40)) - 20) * int'($urandom_range(1, 50));
                return operand_t'(v);
            end
            EXTREMES:
            begin
                case ($urandom_range(0, 7))
                    0:       v = OP_MIN;
                    1:       v = OP_MIN + 1;
                    2:       v = -1;
                    3:       v = 0;
                    4:       v = 1;
                    5:       v = OP_MAX - 1;
                    6:       v = OP_MAX;
                    default: v = OP_MIN + int'($urandom_range(0, 255));
                endcase
                return operand_t'(v);
            end
            default: return operand_t'($urandom);
        endcase
    endfunction

    function automatic operand_t random_divisor(operand_mix_t mix, int zero_pct);
        operand_t v;
        if (int'($urandom_range(0, 99)) < zero_pct)
            return '0;
        v = random_operand(mix);
        while (v == 0)
            v = random_operand(mix);
        return v;
    endfunction

    function automatic operands_t random_item(operand_mix_t mix, int zero_pct);
        operands_t op;
        op.cmd = rar_pkg::cmd_t'($urandom_range(0, 3));
        op.an  = random_operand(mix);
        op.ad  = random_divisor(mix, zero_pct);
        op.bd  = random_divisor(mix, zero_pct);
        if (op.cmd == rar_pkg::CMD_DIV)
            op.bn = random_divisor(mix, zero_pct);
        else
            op.bn = random_operand(mix);
        return op;
    endfunction

    function automatic operands_t make_item(rar_pkg::cmd_t cmd, int an, int ad, int bn, int bd);
        operands_t op;
        op.cmd = cmd;
        op.an  = operand_t'(an);
        op.ad  = operand_t'(ad);
        op.bn  = operand_t'(bn);
        op.bd  = operand_t'(bd);
        return op;
    endfunction

    // Present one item, hold it until accepted, then record its reduced result
    task automatic send_item(operands_t op);
        int        gap;
        fraction_t want;
        gap = pick_idle(sender_idles);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= op.cmd;
        a_num    <= op.an;
        a_den    <= op.ad;
        b_num    <= op.bn;
        b_den    <= op.bd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want = reduced_fraction(op);
        expected_fractions.push_back(want);
        cmd_count[op.cmd]++;
        if (want.err)
            error_items++;
    endtask

    // Compare each result with the oldest expectation, then drive out_ready
    always @(posedge clk)
    begin : check_results
        fraction_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_fractions.size() == 0)
            begin
                $error("result %0d/%0d status %0b with no pending item", res_num, res_den,
                       status);
                mismatches++;
            end
            else
            begin
                want = expected_fractions.pop_front();
                if (res_num !== want.num)
                begin
                    $error("res_num mismatch: expected %0d, got %0d", want.num, res_num);
                    mismatches++;
                end
                if (res_den !== want.den)
                begin
                    $error("res_den mismatch: expected %0d, got %0d", want.den, res_den);
                    mismatches++;
                end
                if (status !== want.err)
                begin
                    $error("status mismatch: expected %0b, got %0b", want.err, status);
                    mismatches++;
                end
            end
        end
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left = pick_idle(receiver_idles);
        end
    end

    task automatic test_normalize;
        send_item(make_item(rar_pkg::CMD_NORM, 6, -4, 0, 0));
        send_item(make_item(rar_pkg::CMD_NORM, 0, -5, 3, 7));
        send_item(make_item(rar_pkg::CMD_NORM, OP_MIN, OP_MIN, 1, 1));
        send_item(make_item(rar_pkg::CMD_NORM, OP_MAX, OP_MIN, -1, 2));
        send_item(make_item(rar_pkg::CMD_NORM, OP_MIN, -1, 5, 5));
        send_item(make_item(rar_pkg::CMD_NORM, 5, 0, 1, 1));
    endtask

    task automatic test_add;
        send_item(make_item(rar_pkg::CMD_ADD, 1, 2, 1, 3));
        send_item(make_item(rar_pkg::CMD_ADD, OP_MIN, 1, OP_MIN, 1));
        send_item(make_item(rar_pkg::CMD_ADD, OP_MAX, 1, OP_MAX, 1));
        send_item(make_item(rar_pkg::CMD_ADD, 1, OP_MAX, 1, OP_MIN));
        send_item(make_item(rar_pkg::CMD_ADD, 3, 4, -3, 4));
        send_item(make_item(rar_pkg::CMD_ADD, 1, 2, 1, 0));
        send_item(make_item(rar_pkg::CMD_ADD, 1, 0, 1, 2));
    endtask

    task automatic test_divide;
        send_item(make_item(rar_pkg::CMD_DIV, OP_MIN, 1, 1, OP_MAX));
        send_item(make_item(rar_pkg::CMD_DIV, 1, OP_MAX, OP_MIN, 1));
        send_item(make_item(rar_pkg::CMD_DIV, 2, 3, 0, 5));
        send_item(make_item(rar_pkg::CMD_DIV, 2, 3, 5, 0));
        send_item(make_item(rar_pkg::CMD_DIV, -4, 6, 2, -3));
    endtask

    task automatic test_increment;
        send_item(make_item(rar_pkg::CMD_INC, -1, 1, 9, 9));
        send_item(make_item(rar_pkg::CMD_INC, OP_MAX, 1, 0, 0));
        // b is unused here, so a zero b denominator must not flag
        send_item(make_item(rar_pkg::CMD_INC, 1, OP_MIN, 7, 0));
        send_item(make_item(rar_pkg::CMD_INC, 3, 0, 1, 1));
    endtask

    task automatic test_random_full_range(int count);
        repeat (count) send_item(random_item(FULL_RANGE, 3));
    endtask

    task automatic test_random_common_factors(int count);
        repeat (count) send_item(random_item(SMALL_FACTORS, 3));
    endtask

    task automatic test_random_extremes(int count);
        repeat (count) send_item(random_item(EXTREMES, 2));
    endtask

    task automatic test_random_error_mix(int count);
        repeat (count) send_item(random_item(FULL_RANGE, 30));
    endtask

    // Run with no gaps on either side
    task automatic test_back_to_back(int count);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        repeat (count) send_item(random_item(SMALL_FACTORS, 3));
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_normalize();
        test_add();
        test_divide();
        test_increment();
        test_random_full_range(700);
        test_random_common_factors(350);
        test_back_to_back(200);
        test_random_extremes(200);
        test_random_error_mix(150);

        // Drain the remaining results, then watch for strays
        in_valid <= 1'b0;
        while (expected_fractions.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);

        $display("Checked %0d results: %0d normalize, %0d add, %0d divide, %0d increment",
                 results_seen, cmd_count[rar_pkg::CMD_NORM], cmd_count[rar_pkg::CMD_ADD],
                 cmd_count[rar_pkg::CMD_DIV], cmd_count[rar_pkg::CMD_INC]);
        $display("%0d items took the zero-denominator path; %0d mismatches", error_items,
                 mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
